// ===== rtl/segment_intersection_defines.svh =====
// Assertion macros used by the checker in rtl/si_checker.sv.
`ifndef SEGMENT_INTERSECTION_DEFINES_SVH
`define SEGMENT_INTERSECTION_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define SI_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define SI_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/si_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package si_pkg;

  localparam int COORD_BITS = 16;
  localparam int DIFF_BITS  = COORD_BITS + 1;
  localparam int PROD_BITS  = 2 * DIFF_BITS;
  localparam int CROSS_BITS = PROD_BITS + 1;
  localparam int Q_BITS     = DIFF_BITS;
  localparam int NUM_BITS   = DIFF_BITS + CROSS_BITS;
  localparam int SUM_BITS   = COORD_BITS + 2;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [DIFF_BITS-1:0]  diff_t;
  typedef logic signed [PROD_BITS-1:0]  prod_t;
  typedef logic signed [CROSS_BITS-1:0] cross_t;

  typedef struct packed {
    coord_t a_start_x;
    coord_t a_start_y;
    coord_t a_end_x;
    coord_t a_end_y;
    coord_t b_start_x;
    coord_t b_start_y;
    coord_t b_end_x;
    coord_t b_end_y;
  } seg_t;

  typedef struct packed {
    logic   hit;
    coord_t cross_x;
    coord_t cross_y;
  } res_t;

  // Work carried along the divider chain, both lanes side by side.
  typedef struct packed {
    logic                  hit;
    coord_t                base_x;
    coord_t                base_y;
    logic                  neg_x;
    logic                  neg_y;
    logic [CROSS_BITS-1:0] den;
    logic [CROSS_BITS-1:0] rem_x;
    logic [CROSS_BITS-1:0] rem_y;
    logic [Q_BITS-1:0]     low_x;
    logic [Q_BITS-1:0]     low_y;
    logic [Q_BITS-1:0]     q_x;
    logic [Q_BITS-1:0]     q_y;
  } div_t;

  function automatic diff_t ext_coord(input coord_t v);
    return DIFF_BITS'(v);
  endfunction

endpackage
`default_nettype wire

// ===== rtl/segment_intersection.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Segment pair intersection by exact integer cross products. One request is
// taken per cycle while no result is stalled, and each passes through five
// front stages (edge vectors, products, cross products, sign fix, range test
// with the numerator multiply), a chain of 17 divider cells that each settle
// one quotient bit for x and y, and an output register. A stalled result
// holds the whole pipeline. Misses report hit low with both coordinates all ones.
module segment_intersection
  import si_pkg::*;
(
  input  wire  clk,
  input  wire  rst,
  input  wire  seg_valid,
  output logic seg_ready,
  input  seg_t seg,
  output logic res_valid,
  input  wire  res_ready,
  output res_t res
);

  logic en;
  logic [Q_BITS:0] cv;
  div_t            cd [Q_BITS+1];

  logic signed [SUM_BITS-1:0] w_x, w_y, f_x, f_y;
  div_t last;

  assign en        = !res_valid || res_ready;
  assign seg_ready = en;

  si_front u_front (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .seg_valid (seg_valid),
    .seg       (seg),
    .dv_valid  (cv[0]),
    .dv        (cd[0])
  );

  for (genvar i = 0; i < Q_BITS; i++) begin : g_cell
    si_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .en         (en),
      .din_valid  (cv[i]),
      .din        (cd[i]),
      .dout_valid (cv[i+1]),
      .dout       (cd[i+1])
    );
  end

  // add the quotient to the start point and truncate toward zero
  always_comb begin
    last = cd[Q_BITS];
    w_x  = last.neg_x ? SUM_BITS'(last.base_x) - SUM_BITS'(last.q_x)
                      : SUM_BITS'(last.base_x) + SUM_BITS'(last.q_x);
    w_y  = last.neg_y ? SUM_BITS'(last.base_y) - SUM_BITS'(last.q_y)
                      : SUM_BITS'(last.base_y) + SUM_BITS'(last.q_y);
    f_x  = w_x;
    f_y  = w_y;
    if (last.rem_x != '0) begin
      if (!last.neg_x && w_x < 0) f_x = w_x + SUM_BITS'(1);
      if (last.neg_x && w_x > 0)  f_x = w_x - SUM_BITS'(1);
    end
    if (last.rem_y != '0) begin
      if (!last.neg_y && w_y < 0) f_y = w_y + SUM_BITS'(1);
      if (last.neg_y && w_y > 0)  f_y = w_y - SUM_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (en) begin
      res_valid <= cv[Q_BITS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res.hit     <= last.hit;
      res.cross_x <= last.hit ? f_x[COORD_BITS-1:0] : '1;
      res.cross_y <= last.hit ? f_y[COORD_BITS-1:0] : '1;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/si_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
module si_front
  import si_pkg::*;
(
  input  wire  clk,
  input  wire  rst,
  input  wire  en,
  input  wire  seg_valid,
  input  seg_t seg,
  output logic dv_valid,
  output div_t dv
);

  logic [4:0] valid;

  // stage 1: edge vectors
  coord_t s1_ax, s1_ay;
  diff_t  s1_rx, s1_ry, s1_sx, s1_sy, s1_dx, s1_dy;
  // stage 2: products
  coord_t s2_ax, s2_ay;
  diff_t  s2_rx, s2_ry;
  prod_t  p_d0, p_d1, p_t0, p_t1, p_u0, p_u1;
  // stage 3: cross products
  coord_t s3_ax, s3_ay;
  logic   s3_nx, s3_ny;
  logic [DIFF_BITS-1:0] s3_mx, s3_my;
  cross_t s3_den, s3_tn, s3_un;
  // stage 4: sign normalized
  coord_t s4_ax, s4_ay;
  logic   s4_nx, s4_ny;
  logic [DIFF_BITS-1:0] s4_mx, s4_my;
  cross_t s4_den, s4_tn, s4_un;

  logic                s5_hit;
  logic [NUM_BITS-1:0] num_x, num_y;

  // advance valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (en) begin
      valid <= {valid[3:0], seg_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_ax <= seg.a_start_x;
      s1_ay <= seg.a_start_y;
      s1_rx <= ext_coord(seg.a_end_x) - ext_coord(seg.a_start_x);
      s1_ry <= ext_coord(seg.a_end_y) - ext_coord(seg.a_start_y);
      s1_sx <= ext_coord(seg.b_end_x) - ext_coord(seg.b_start_x);
      s1_sy <= ext_coord(seg.b_end_y) - ext_coord(seg.b_start_y);
      s1_dx <= ext_coord(seg.b_start_x) - ext_coord(seg.a_start_x);
      s1_dy <= ext_coord(seg.b_start_y) - ext_coord(seg.a_start_y);

      s2_ax <= s1_ax;
      s2_ay <= s1_ay;
      s2_rx <= s1_rx;
      s2_ry <= s1_ry;
      p_d0  <= s1_rx * s1_sy;
      p_d1  <= s1_ry * s1_sx;
      p_t0  <= s1_dx * s1_sy;
      p_t1  <= s1_dy * s1_sx;
      p_u0  <= s1_dx * s1_ry;
      p_u1  <= s1_dy * s1_rx;

      s3_ax  <= s2_ax;
      s3_ay  <= s2_ay;
      s3_nx  <= s2_rx[DIFF_BITS-1];
      s3_ny  <= s2_ry[DIFF_BITS-1];
      s3_mx  <= s2_rx[DIFF_BITS-1] ? DIFF_BITS'(-s2_rx) : DIFF_BITS'(s2_rx);
      s3_my  <= s2_ry[DIFF_BITS-1] ? DIFF_BITS'(-s2_ry) : DIFF_BITS'(s2_ry);
      s3_den <= CROSS_BITS'(p_d0) - CROSS_BITS'(p_d1);
      s3_tn  <= CROSS_BITS'(p_t0) - CROSS_BITS'(p_t1);
      s3_un  <= CROSS_BITS'(p_u0) - CROSS_BITS'(p_u1);

      s4_ax <= s3_ax;
      s4_ay <= s3_ay;
      s4_nx <= s3_nx;
      s4_ny <= s3_ny;
      s4_mx <= s3_mx;
      s4_my <= s3_my;
      if (s3_den[CROSS_BITS-1]) begin
        s4_den <= -s3_den;
        s4_tn  <= -s3_tn;
        s4_un  <= -s3_un;
      end else begin
        s4_den <= s3_den;
        s4_tn  <= s3_tn;
        s4_un  <= s3_un;
      end
    end
  end

  // test both parameters against [0,1] and form the numerators
  always_comb begin
    s5_hit = (s4_den != '0) && !s4_tn[CROSS_BITS-1] && !s4_un[CROSS_BITS-1] &&
             (s4_tn <= s4_den) && (s4_un <= s4_den);
    num_x  = NUM_BITS'(s4_mx) * NUM_BITS'($unsigned(s4_tn));
    num_y  = NUM_BITS'(s4_my) * NUM_BITS'($unsigned(s4_tn));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dv.hit    <= s5_hit;
      dv.base_x <= s4_ax;
      dv.base_y <= s4_ay;
      dv.neg_x  <= s4_nx;
      dv.neg_y  <= s4_ny;
      dv.den    <= $unsigned(s4_den);
      dv.rem_x  <= num_x[NUM_BITS-1:Q_BITS];
      dv.rem_y  <= num_y[NUM_BITS-1:Q_BITS];
      dv.low_x  <= num_x[Q_BITS-1:0];
      dv.low_y  <= num_y[Q_BITS-1:0];
      dv.q_x    <= '0;
      dv.q_y    <= '0;
    end
  end

  assign dv_valid = valid[4];

endmodule
`default_nettype wire

// ===== rtl/si_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none
module si_cell
  import si_pkg::*;
(
  input  wire  clk,
  input  wire  rst,
  input  wire  en,
  input  wire  din_valid,
  input  div_t din,
  output logic dout_valid,
  output div_t dout
);

  logic [CROSS_BITS+1:0] diff_x, diff_y;
  div_t nxt;

  // one restoring step per lane: shift in the next bit, subtract if it fits
  always_comb begin
    nxt    = din;
    diff_x = {1'b0, din.rem_x, din.low_x[Q_BITS-1]} - {2'b00, din.den};
    diff_y = {1'b0, din.rem_y, din.low_y[Q_BITS-1]} - {2'b00, din.den};
    nxt.low_x = {din.low_x[Q_BITS-2:0], 1'b0};
    nxt.low_y = {din.low_y[Q_BITS-2:0], 1'b0};
    nxt.q_x   = {din.q_x[Q_BITS-2:0], !diff_x[CROSS_BITS+1]};
    nxt.q_y   = {din.q_y[Q_BITS-2:0], !diff_y[CROSS_BITS+1]};
    nxt.rem_x = diff_x[CROSS_BITS+1] ? {din.rem_x[CROSS_BITS-2:0], din.low_x[Q_BITS-1]}
                                     : diff_x[CROSS_BITS-1:0];
    nxt.rem_y = diff_y[CROSS_BITS+1] ? {din.rem_y[CROSS_BITS-2:0], din.low_y[Q_BITS-1]}
                                     : diff_y[CROSS_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dout_valid <= 1'b0;
    end else if (en) begin
      dout_valid <= din_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dout <= nxt;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/si_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "segment_intersection_defines.svh"
module si_checker
  import si_pkg::*;
(
  input wire  clk,
  input wire  rst,
  input wire  seg_ready,
  input wire  res_valid,
  input wire  res_ready,
  input res_t res
);

  // a stalled result holds
  `SI_ASSERT_NEXT(a_res_hold, clk, rst, res_valid && !res_ready, res_valid && $stable(res), "result moved")
  // a miss carries all-ones coordinates
  `SI_ASSERT_SAME(a_miss_coords, clk, rst, res_valid && !res.hit, (res.cross_x == '1) && (res.cross_y == '1), "bad miss")
  // a stalled result blocks new requests
  `SI_ASSERT_SAME(a_stall_blocks, clk, rst, res_valid && !res_ready, !seg_ready, "request taken during output stall")
  // an idle output leaves the input open
  `SI_ASSERT_SAME(a_ready_open, clk, rst, !res_valid, seg_ready, "input closed with empty output")

endmodule

bind segment_intersection si_checker u_si_checker (
  .clk       (clk),
  .rst       (rst),
  .seg_ready (seg_ready),
  .res_valid (res_valid),
  .res_ready (res_ready),
  .res       (res)
);
`default_nettype wire

// ===== test/segment_intersection_checker.sv =====
`timescale 1ns / 1ps
module segment_intersection_checker
  import si_pkg::*;
(
  input  wire  clk,
  input  wire  rst,
  input  wire  seg_valid,
  input  wire  seg_ready,
  input  seg_t seg,
  input  wire  res_valid,
  input  wire  res_ready,
  input  res_t res,
  output int   failures,
  output int   pending,
  output int   hits_seen,
  output int   results_seen
);

  res_t expected_points[$];

  // Exact crossing point of two segments; coordinates truncate toward zero.
  function automatic res_t intersect_segments(input seg_t s);
    longint ax, ay, rx, ry, bx, by, sx, sy, dx, dy, den, tn, un;
    res_t r;
    ax = s.a_start_x;
    ay = s.a_start_y;
    rx = longint'(s.a_end_x) - ax;
    ry = longint'(s.a_end_y) - ay;
    bx = s.b_start_x;
    by = s.b_start_y;
    sx = longint'(s.b_end_x) - bx;
    sy = longint'(s.b_end_y) - by;
    dx = bx - ax;
    dy = by - ay;
    den = rx * sy - ry * sx;
    tn = dx * sy - dy * sx;
    un = dx * ry - dy * rx;
    r.hit = 1'b0;
    r.cross_x = '1;
    r.cross_y = '1;
    if (den != 0) begin
      // normalize the sign so both parameters compare against a positive denominator
      if (den < 0) begin
        den = -den;
        tn = -tn;
        un = -un;
      end
      if (tn >= 0 && un >= 0 && tn <= den && un <= den) begin
        r.hit = 1'b1;
        r.cross_x = coord_t'((ax * den + rx * tn) / den);
        r.cross_y = coord_t'((ay * den + ry * tn) / den);
      end
    end
    return r;
  endfunction

  assign pending = expected_points.size();

  // Predict on every accepted request, compare every accepted result
  always @(posedge clk) begin
    res_t want;
    if (rst) begin
      failures <= 0;
      hits_seen <= 0;
      results_seen <= 0;
    end else begin
      if (res_valid && res_ready) begin
        results_seen <= results_seen + 1;
        if (expected_points.size() == 0) begin
          if (failures < 10)
            $display("%0t: unexpected result hit=%0b x=%0d y=%0d",
                     $time, res.hit, res.cross_x, res.cross_y);
          failures <= failures + 1;
        end else begin
          want = expected_points.pop_front();
          if (want.hit) hits_seen <= hits_seen + 1;
          if (res !== want) begin
            if (failures < 10)
              $display("%0t: mismatch expected hit=%0b x=%0d y=%0d, got hit=%0b x=%0d y=%0d",
                       $time, want.hit, want.cross_x, want.cross_y,
                       res.hit, res.cross_x, res.cross_y);
            failures <= failures + 1;
          end
        end
      end
      if (seg_valid && seg_ready)
        expected_points.push_back(intersect_segments(seg));
    end
  end

endmodule

// ===== test/segment_intersection_test.sv =====
`timescale 1ns / 1ps
module segment_intersection_test;
  import si_pkg::*;

  localparam int RANDOM_ITEMS = 800;
  localparam int LONG_HOLD = 300;
  localparam int IDLE_LIMIT = 3000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic seg_valid = 1'b0;
  logic res_ready = 1'b0;
  seg_t seg = '0;
  wire  seg_ready;
  wire  res_valid;
  res_t res;
  int   failures, pending, hits_seen, results_seen;
  int   idle_cycles = 0;
  bit   long_hold_req = 1'b0;
  bit   calm = 1'b0;

  always #5 clk = ~clk;

  segment_intersection uut (
    .clk(clk), .rst(rst),
    .seg_valid(seg_valid), .seg_ready(seg_ready), .seg(seg),
    .res_valid(res_valid), .res_ready(res_ready), .res(res)
  );

  segment_intersection_checker u_checker (
    .clk(clk), .rst(rst),
    .seg_valid(seg_valid), .seg_ready(seg_ready), .seg(seg),
    .res_valid(res_valid), .res_ready(res_ready), .res(res),
    .failures(failures), .pending(pending),
    .hits_seen(hits_seen), .results_seen(results_seen)
  );

  // Abort when no request and no result moves for too long
  always @(posedge clk) begin
    if (!rst) begin
      if ((seg_valid && seg_ready) || (res_valid && res_ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Timeout: no progress for %0d cycles", IDLE_LIMIT);
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  // Offer one request after a random gap and hold it until accepted
  task automatic send_segments(input seg_t v);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 18);
    if (gap > 0) begin
      seg_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    seg <= v;
    seg_valid <= 1'b1;
    do @(posedge clk); while (!seg_ready);
    @(negedge clk);
  endtask

  task automatic drain;
    seg_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  function automatic seg_t make_seg(input int ax, ay, bx, by, cx, cy, dx, dy);
    seg_t s;
    s.a_start_x = coord_t'(ax);
    s.a_start_y = coord_t'(ay);
    s.a_end_x = coord_t'(bx);
    s.a_end_y = coord_t'(by);
    s.b_start_x = coord_t'(cx);
    s.b_start_y = coord_t'(cy);
    s.b_end_x = coord_t'(dx);
    s.b_end_y = coord_t'(dy);
    return s;
  endfunction

  function automatic int rnd_coord(input int span);
    return int'($urandom_range(0, 2 * span)) - span;
  endfunction

  // Receiver: random stall per result, a long hold-off on request
  initial begin
    int k;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (long_hold_req) begin
        res_ready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
        long_hold_req = 1'b0;
      end
      k = calm ? 0 : $urandom_range(0, 18);
      if (k > 0) begin
        res_ready <= 1'b0;
        repeat (k) @(negedge clk);
      end
      res_ready <= 1'b1;
      do @(posedge clk); while (!res_valid);
      @(negedge clk);
    end
  end

  initial begin
    seg_t s;
    int px, py, kind, span;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: crossings, touching ends, parallel, collinear, points, extremes
    send_segments(make_seg(0, 0, 10, 10, 0, 10, 10, 0));
    send_segments(make_seg(0, 0, 10, 0, 10, 0, 10, 10));
    send_segments(make_seg(0, 0, 10, 0, 5, 0, 5, 7));
    send_segments(make_seg(0, 0, 10, 0, 0, 1, 10, 1));
    send_segments(make_seg(0, 0, 10, 0, 3, 0, 20, 0));
    send_segments(make_seg(4, 4, 4, 4, 0, 0, 10, 10));
    send_segments(make_seg(4, 4, 4, 4, 4, 4, 4, 4));
    send_segments(make_seg(0, 0, 3, 1, 0, 1, 3, 0));
    send_segments(make_seg(0, 0, -3, -1, 0, -1, -3, 0));
    send_segments(make_seg(0, 0, 10, 10, 0, 10, 4, 6));
    send_segments(make_seg(-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768));
    send_segments(make_seg(32767, -32768, -32768, 32767, -32768, -32768, 32767, 32767));
    send_segments(make_seg(-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768));
    send_segments(make_seg(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767));
    send_segments(make_seg(-32768, 0, 32767, 1, 0, -32768, 1, 32767));
    send_segments(make_seg(-32768, -32768, 32767, 32767, -32768, -32767, 32767, 32766));
    send_segments(make_seg(0, 10, 10, 0, 0, 0, 10, 10));
    send_segments(make_seg(-7, 3, 5, -2, -1, -6, 2, 9));
    drain();

    // Random: small boxes for many hits, built crossings, near-parallel, full range
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == 100) long_hold_req = 1'b1;
      if (i == 400) drain();
      calm = (i >= 250 && i < 330);
      kind = $urandom_range(0, 9);
      span = ($urandom_range(0, 3) == 0) ? 32767 : 60;
      if (kind < 3) begin
        px = rnd_coord(20000);
        py = rnd_coord(20000);
        s = make_seg(px - rnd_coord(span), py - rnd_coord(span),
                     px + rnd_coord(span), py + rnd_coord(span),
                     px - rnd_coord(span), py - rnd_coord(span),
                     px + rnd_coord(span), py + rnd_coord(span));
        if (span == 32767) s = make_seg(rnd_coord(32767), rnd_coord(32767),
                                        rnd_coord(32767), rnd_coord(32767),
                                        px, py, -px, -py);
      end else if (kind < 6) begin
        s = make_seg(rnd_coord(40), rnd_coord(40), rnd_coord(40), rnd_coord(40),
                     rnd_coord(40), rnd_coord(40), rnd_coord(40), rnd_coord(40));
      end else if (kind == 6) begin
        px = rnd_coord(1000);
        py = rnd_coord(1000);
        s.a_start_x = coord_t'(rnd_coord(30000));
        s.a_start_y = coord_t'(rnd_coord(30000));
        s.a_end_x = coord_t'(s.a_start_x + px);
        s.a_end_y = coord_t'(s.a_start_y + py);
        s.b_start_x = coord_t'(s.a_start_x + rnd_coord(3));
        s.b_start_y = coord_t'(s.a_start_y + rnd_coord(3));
        s.b_end_x = coord_t'(s.b_start_x + px);
        s.b_end_y = coord_t'(s.b_start_y + py);
      end else begin
        s = seg_t'({$urandom, $urandom, $urandom, $urandom});
      end
      send_segments(s);
    end

    drain();
    repeat (40) @(negedge clk);
    $display("Ran %0d results through the pipeline, %0d of them crossings,", results_seen,
             hits_seen);
    $display("with random stalls on both sides, a long output hold-off and idle drains.");
    if (failures == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/si_pkg.sv
rtl/si_front.sv
rtl/si_cell.sv
rtl/segment_intersection.sv
rtl/si_checker.sv
test/segment_intersection_checker.sv
test/segment_intersection_test.sv
